// File: rtl/core/stce_pkg.sv
// Package for the skyline to coordinate expander.
// Holds the transfer payload structs, command and status codes, and register map.
// No dependencies; used by skyline_to_coordinate_expander.
`timescale 1ns / 1ps
`default_nettype none

package stce_pkg;

    localparam int ADDR_BITS = 3;

    // Row and column positions carry one bit above the 16-bit coordinate fields.
    localparam int COORD_BITS = 16;

    // Register index, taken from paddr[2].
    localparam logic REG_DIMENSION   = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    localparam logic CMD_INDEX = 1'b0;
    localparam logic CMD_VALUE = 1'b1;

    localparam logic [2:0] ST_ENTRY      = 3'd0;
    localparam logic [2:0] ST_RANGE      = 3'd1;
    localparam logic [2:0] ST_CAPACITY   = 3'd2;
    localparam logic [2:0] ST_UNEXPECTED = 3'd3;
    localparam logic [2:0] ST_DECREASING = 3'd4;

    typedef struct packed {
        logic        command;
        logic [63:0] word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/skyline_to_coordinate_expander.sv
// Path: an accepted item waits in the input register until the result buffer has room for
// all of its results, which are then written into the result buffer that drives out_valid.
// Throughput: one item per cycle while items give at most one result and the receiver
// keeps out_ready high; an off-diagonal entry gives two results, and the single result
// port with its three-entry result buffer then holds the input back.
// Reset: rst_n asynchronously clears the column state and entry count, empties the input
// register and result buffer, and sets dimension to 0 and max_entries to all ones.
// Top level of the skyline to coordinate expander.
// Depends on stce_pkg for payload structs, codes and the register map.
`timescale 1ns / 1ps
`default_nettype none

module skyline_to_coordinate_expander #(
    parameter int INDEX_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire stce_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output stce_pkg::out_item_t              out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [stce_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int PW = stce_pkg::COORD_BITS + 1;

    // Configuration registers.
    logic [15:0] dimension_reg;
    logic [31:0] max_entries_reg;

    // Column walk state.
    logic                  seen_first_reg, seen_first_next;
    logic [INDEX_BITS-1:0] prev_index_reg, prev_index_next;
    logic [PW-1:0]         next_col_reg, next_col_next;
    logic [PW-1:0]         cur_col_reg, cur_col_next;
    logic [PW-1:0]         cur_row_reg, cur_row_next;
    logic [INDEX_BITS-1:0] remaining_reg, remaining_next;
    logic [31:0]           entry_count_reg, entry_count_next;

    // Input register.
    logic                 pend_valid_reg;
    stce_pkg::in_item_t   pend_reg;

    // Result buffer: three entries, head at rd_ptr_reg.
    stce_pkg::out_item_t  res_buf_reg [3];
    logic [1:0]           rd_ptr_reg, wr_ptr_reg, count_reg;
    logic [1:0]           count_next;

    logic                 in_xfer, out_xfer, proc;
    logic [1:0]           n_res;
    stce_pkg::out_item_t  res0, res1;
    logic [1:0]           wr_ptr_1;

    logic                  cfg_write;
    logic [INDEX_BITS-1:0] idx;
    logic [PW+15:0]        row_wide, col_wide, lim_wide, dim_wide;

    function automatic logic [1:0] inc3(input logic [1:0] p);
        inc3 = (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            stce_pkg::REG_DIMENSION:   prdata = {16'b0, dimension_reg};
            stce_pkg::REG_MAX_ENTRIES: prdata = max_entries_reg;
            default:                   prdata = 32'b0;
        endcase
    end

    // ---------------------------------------------------------------- item logic
    assign idx      = pend_reg.word[INDEX_BITS-1:0];
    assign row_wide = {16'b0, cur_row_reg};
    assign col_wide = {16'b0, cur_col_reg};
    assign lim_wide = {PW'(0), 16'hFFFF};
    assign dim_wide = {PW'(0), dimension_reg};

    always_comb
    begin
        logic        ok0;
        logic        ok1;
        logic [31:0] cnt1;

        seen_first_next  = seen_first_reg;
        prev_index_next  = prev_index_reg;
        next_col_next    = next_col_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        remaining_next   = remaining_reg;
        entry_count_next = entry_count_reg;
        n_res            = 2'd0;
        res0             = '0;
        res1             = '0;
        ok0              = entry_count_reg < max_entries_reg;
        cnt1             = entry_count_reg + {31'b0, ok0};
        ok1              = cnt1 < max_entries_reg;

        if (pend_reg.command == stce_pkg::CMD_INDEX)
        begin
            if (!seen_first_reg)
            begin
                seen_first_next = 1'b1;
                prev_index_next = idx;
            end
            else if (idx < prev_index_reg)
            begin
                n_res       = 2'd1;
                res0.status = stce_pkg::ST_DECREASING;
            end
            else
            begin
                remaining_next  = idx - prev_index_reg;
                prev_index_next = idx;
                cur_col_next    = next_col_reg;
                cur_row_next    = next_col_reg;
                if (next_col_reg != {PW{1'b1}})
                    next_col_next = next_col_reg + PW'(1);
            end
        end
        else if (remaining_reg == '0)
        begin
            n_res       = 2'd1;
            res0.status = stce_pkg::ST_UNEXPECTED;
        end
        else
        begin
            remaining_next = remaining_reg - INDEX_BITS'(1);
            // Stepping above row 0 parks the row at all ones, which is never in range.
            if (cur_row_reg == '0 || row_wide > lim_wide)
                cur_row_next = {PW{1'b1}};
            else
                cur_row_next = cur_row_reg - PW'(1);

            if (col_wide >= dim_wide || row_wide >= dim_wide)
            begin
                n_res       = 2'd1;
                res0.status = stce_pkg::ST_RANGE;
            end
            else if (pend_reg.word[62:0] != 63'b0)
            begin
                n_res       = 2'd1;
                res0.row    = row_wide[15:0];
                res0.col    = col_wide[15:0];
                res0.value  = pend_reg.word;
                res0.status = ok0 ? stce_pkg::ST_ENTRY : stce_pkg::ST_CAPACITY;
                entry_count_next = cnt1;
                if (cur_row_reg != cur_col_reg)
                begin
                    n_res       = 2'd2;
                    res1.row    = col_wide[15:0];
                    res1.col    = row_wide[15:0];
                    res1.value  = pend_reg.word;
                    res1.status = ok1 ? stce_pkg::ST_ENTRY : stce_pkg::ST_CAPACITY;
                    entry_count_next = cnt1 + {31'b0, ok1};
                end
            end
        end

        if (n_res == 2'd1)
            res0.last = 1'b1;
        if (n_res == 2'd2)
            res1.last = 1'b1;
    end

    // An item is processed only when the buffer has room for all its results.
    assign proc     = pend_valid_reg && ({1'b0, n_res} + {1'b0, count_reg} <= 3'd3);
    assign in_ready = !pend_valid_reg || proc;
    assign in_xfer  = in_valid && in_ready;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = res_buf_reg[rd_ptr_reg];
    assign out_xfer  = out_valid && out_ready;
    assign wr_ptr_1  = inc3(wr_ptr_reg);

    always_comb
    begin
        count_next = count_reg;
        if (proc)
            count_next = count_next + n_res;
        if (out_xfer)
            count_next = count_next - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg   <= '0;
            max_entries_reg <= '1;
            seen_first_reg  <= 1'b0;
            prev_index_reg  <= '0;
            next_col_reg    <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            remaining_reg   <= '0;
            entry_count_reg <= '0;
            pend_valid_reg  <= 1'b0;
            rd_ptr_reg      <= 2'd0;
            wr_ptr_reg      <= 2'd0;
            count_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[2])
                    stce_pkg::REG_DIMENSION:   dimension_reg   <= pwdata[15:0];
                    stce_pkg::REG_MAX_ENTRIES: max_entries_reg <= pwdata;
                    default:                   ;
                endcase
            end
            if (proc)
            begin
                seen_first_reg  <= seen_first_next;
                prev_index_reg  <= prev_index_next;
                next_col_reg    <= next_col_next;
                cur_col_reg     <= cur_col_next;
                cur_row_reg     <= cur_row_next;
                remaining_reg   <= remaining_next;
                entry_count_reg <= entry_count_next;
                if (n_res == 2'd1)
                    wr_ptr_reg <= wr_ptr_1;
                else if (n_res == 2'd2)
                    wr_ptr_reg <= inc3(wr_ptr_1);
            end
            if (in_xfer)
                pend_valid_reg <= 1'b1;
            else if (proc)
                pend_valid_reg <= 1'b0;
            if (out_xfer)
                rd_ptr_reg <= inc3(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            pend_reg <= in_data;
        if (proc && n_res != 2'd0)
            res_buf_reg[wr_ptr_reg] <= res0;
        if (proc && n_res == 2'd2)
            res_buf_reg[wr_ptr_1] <= res1;
    end

    // ---------------------------------------------------------------- checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd3)
        else $error("result buffer count out of range");

    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd3) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("result buffer pointers disagree with count");

    a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> entry_count_reg >= $past(entry_count_reg))
        else $error("entry count decreased");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !proc) |=> (pend_valid_reg && $stable(pend_reg)))
        else $error("stalled item lost from input register");

endmodule

`default_nettype wire

// File: dv/skyline_to_coordinate_expander_tb.sv
// Self-checking testbench for the skyline to coordinate expander.
// Predicts the coordinate results of each accepted skyline word and checks the output transfers.
// Depends on stce_pkg and skyline_to_coordinate_expander.
`timescale 1ns / 1ps

module skyline_to_coordinate_expander_tb;

    import stce_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [16:0] COORD_ONES  = '1;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr  = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    skyline_to_coordinate_expander i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Words waiting to be offered, and coordinate results waiting to arrive.
    in_item_t  pending_words[$];
    out_item_t expected_coords[$];

    int unsigned idle_pct       = 24;
    int unsigned error_count    = 0;
    int unsigned stall_cycles   = 0;
    int unsigned holdoff_left   = 0;
    bit          holdoff_req    = 1'b0;
    bit          holdoff_taken  = 1'b0;

    // Expander state as seen by the predictor.
    logic [15:0] cfg_dimension   = 16'd0;
    logic [31:0] cfg_max_entries = 32'hFFFF_FFFF;
    logic        seen_first_index = 1'b0;
    logic [31:0] prev_index  = '0;
    logic [16:0] next_col    = '0;
    logic [16:0] cur_col     = '0;
    logic [16:0] cur_row     = '0;
    logic [31:0] values_left = '0;
    logic [31:0] entry_count = '0;

    // Generator's own view of the index stream, so that columns stay well formed.
    logic        gen_started = 1'b0;
    logic [31:0] gen_prev    = '0;
    int unsigned gen_col     = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic out_item_t coord_entry(input logic [16:0] r, input logic [16:0] c,
                                              input logic [63:0] v);
        out_item_t e;
        e       = '0;
        e.row   = r[15:0];
        e.col   = c[15:0];
        e.value = v;
        if (entry_count < cfg_max_entries)
        begin
            entry_count++;
            e.status = ST_ENTRY;
        end
        else
        begin
            e.status = ST_CAPACITY;
        end
        return e;
    endfunction

    function automatic void expand_skyline_word(input in_item_t item);
        out_item_t   made[$];
        out_item_t   res;
        logic [31:0] idx;
        logic [16:0] r;
        logic [16:0] c;
        idx = item.word[31:0];
        res = '0;
        if (item.command == CMD_INDEX)
        begin
            if (!seen_first_index)
            begin
                seen_first_index = 1'b1;
                prev_index       = idx;
            end
            else if (idx < prev_index)
            begin
                res.status = ST_DECREASING;
                made.push_back(res);
            end
            else
            begin
                values_left = idx - prev_index;
                prev_index  = idx;
                cur_col     = next_col;
                cur_row     = next_col;
                if (next_col != COORD_ONES)
                    next_col++;
            end
        end
        else if (values_left == '0)
        begin
            res.status = ST_UNEXPECTED;
            made.push_back(res);
        end
        else
        begin
            values_left--;
            r = cur_row;
            c = cur_col;
            // Stepping up past row 0 parks the row at all ones, which is never in range.
            if (cur_row == '0 || cur_row > 17'h0FFFF)
                cur_row = COORD_ONES;
            else
                cur_row--;
            if (c >= {1'b0, cfg_dimension} || r >= {1'b0, cfg_dimension})
            begin
                res.status = ST_RANGE;
                made.push_back(res);
            end
            else if (item.word[62:0] != '0)
            begin
                made.push_back(coord_entry(r, c, item.word));
                if (r != c)
                    made.push_back(coord_entry(c, r, item.word));
            end
        end
        if (made.size() > 0)
        begin
            res      = made[made.size() - 1];
            res.last = 1'b1;
            made[made.size() - 1] = res;
        end
        foreach (made[k])
            expected_coords.push_back(made[k]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Driver: offers queued words and predicts each accepted transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expand_skyline_word(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_words.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and drives the receiver's stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_coords.size() == 0)
                begin
                    report_mismatch("result with nothing expected", out_data.value, '0);
                end
                else
                begin
                    if (out_data.row !== expected_coords[0].row)
                        report_mismatch("row", out_data.row, expected_coords[0].row);
                    if (out_data.col !== expected_coords[0].col)
                        report_mismatch("col", out_data.col, expected_coords[0].col);
                    if (out_data.value !== expected_coords[0].value)
                        report_mismatch("value", out_data.value, expected_coords[0].value);
                    if (out_data.status !== expected_coords[0].status)
                        report_mismatch("status", out_data.status, expected_coords[0].status);
                    if (out_data.last !== expected_coords[0].last)
                        report_mismatch("last", out_data.last, expected_coords[0].last);
                    void'(expected_coords.pop_front());
                end
            end
            if (holdoff_req && !holdoff_taken)
            begin
                holdoff_taken = 1'b1;
                holdoff_left  = 300;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_register(input logic sel, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_DIMENSION)
            cfg_dimension = data[15:0];
        else
            cfg_max_entries = data;
        @(negedge clk);
    endtask

    task automatic push_index(input logic [31:0] idx);
        in_item_t w;
        w.command = CMD_INDEX;
        w.word    = {$urandom, idx};
        pending_words.push_back(w);
        if (!gen_started)
        begin
            gen_started = 1'b1;
            gen_prev    = idx;
        end
        else if (idx >= gen_prev)
        begin
            gen_prev = idx;
            gen_col++;
        end
    endtask

    task automatic push_value(input logic [63:0] v);
        in_item_t w;
        w.command = CMD_VALUE;
        w.word    = v;
        pending_words.push_back(w);
    endtask

    function automatic logic [63:0] random_double();
        case ($urandom_range(9))
            0, 1:    return 64'h0;
            2:       return 64'h8000_0000_0000_0000;
            3:       return {1'b0, 11'h7FF, 20'h80000, 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly columns, some with too few or one too many values; the rest are stray values and decreasing indexes.
    task automatic queue_random_items(input int unsigned count);
        int unsigned n;
        int unsigned pick;
        int unsigned h;
        int unsigned k;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                push_value(random_double());
                n++;
            end
            else if (pick < 14)
            begin
                push_index($urandom_range(0, gen_prev - 1));
                n++;
            end
            else
            begin
                h = ($urandom_range(99) < 60) ? $urandom_range(0, 4) : $urandom_range(5, 16);
                pick = $urandom_range(99);
                if (pick < 70)
                    k = h;
                else if (pick < 85)
                    k = $urandom_range(0, h);
                else
                    k = h + 1;
                push_index(gen_prev + h);
                n++;
                repeat (k)
                begin
                    push_value(random_double());
                    n++;
                end
            end
        end
    endtask

    // Waits until every queued word is taken and every result is in, then lets
    // the pipeline settle, since the last words may have caused no result.
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_coords.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_register(REG_DIMENSION, 32'd6);
        write_register(REG_MAX_ENTRIES, 32'd4);

        // Directed: value before any index, first index, diagonal and mirrored
        // entries, row underflow, signed zeros, NaN, capacity, dropped column rest,
        // decreasing index, empty column and a column beyond the dimension.
        push_value(64'h3FF0_0000_0000_0000);
        push_index(32'h8000_0000);
        push_value(64'h0000_0000_0000_0001);
        push_index(32'h8000_0003);
        push_value(64'h4000_0000_0000_0000);
        push_value(64'hFFF0_0000_0000_0000);
        push_value(64'h0);
        push_index(32'h8000_0005);
        push_value(64'h0000_0000_0000_0001);
        push_value(64'hC008_0000_0000_0000);
        push_index(32'h8000_0009);
        push_value(64'h0);
        push_value(64'h8000_0000_0000_0000);
        push_value(64'h7FF8_0000_0000_0000);
        push_value(64'h3FF0_0000_0000_0000);
        push_index(32'h8000_000E);
        push_value(64'h3FF0_0000_0000_0000);
        push_index(32'h7FFF_FFFF);
        push_index(32'h8000_000F);
        push_value(64'hFFFF_FFFF_FFFF_FFFF);
        push_index(32'h8000_000F);
        push_value(64'h4000_0000_0000_0000);
        push_index(32'h8000_0011);
        push_value(64'h4000_0000_0000_0000);
        wait_drained();

        write_register(REG_DIMENSION, 32'd65535);
        write_register(REG_MAX_ENTRIES, 32'hFFFF_FFFF);
        queue_random_items(400);
        wait_drained();

        // Dimension just above the open columns, capacity about to run out, no idling.
        write_register(REG_DIMENSION, gen_col + 8);
        write_register(REG_MAX_ENTRIES, entry_count + 30);
        idle_pct = 0;
        queue_random_items(400);
        wait_drained();

        write_register(REG_DIMENSION, 32'd0);
        write_register(REG_MAX_ENTRIES, 32'd0);
        idle_pct = 24;
        queue_random_items(150);
        wait_drained();

        // The receiver holds off for a long stretch while words keep coming.
        write_register(REG_DIMENSION, 32'd65535);
        write_register(REG_MAX_ENTRIES, 32'hFFFF_FFFF);
        queue_random_items(400);
        holdoff_req = 1'b1;
        wait_drained();

        // A few empty columns, then filled ones across the dimension's edge and a
        // final index at its maximum.
        write_register(REG_DIMENSION, gen_col + 4);
        repeat (3)
            push_index(gen_prev);
        repeat (5)
        begin
            push_index(gen_prev + 3);
            repeat (3)
                push_value({$urandom, $urandom} | 64'h1);
        end
        push_index(32'hFFFF_FFFF);
        push_value(random_double());
        push_value(64'h3FF0_0000_0000_0000);
        wait_drained();

        repeat (10) @(negedge clk);
        if (expected_coords.size() != 0)
            report_mismatch("results never arrived", expected_coords.size(), '0);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/core/stce_pkg.sv
rtl/core/skyline_to_coordinate_expander.sv
dv/skyline_to_coordinate_expander_tb.sv
